/* rtl/i2cbm_pkg.sv */
`default_nettype none

package i2cbm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int HALF_BITS  = 16;
    localparam logic [HALF_BITS-1:0] HALF_RESET = 16'd50;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6,
        CMD_ADDR  = 3'd7
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_ST_C   = 5'd3,
        PH_SP_A   = 5'd4,
        PH_SP_B   = 5'd5,
        PH_WR_SET = 5'd6,
        PH_WR_HI  = 5'd7,
        PH_WR_LO  = 5'd8,
        PH_AK_REL = 5'd9,
        PH_AK_HI  = 5'd10,
        PH_AK_LO  = 5'd11,
        PH_AK_END = 5'd12,
        PH_RD_REL = 5'd13,
        PH_RD_HI  = 5'd14,
        PH_RD_LO  = 5'd15,
        PH_RD_END = 5'd16,
        PH_MA_SET = 5'd17,
        PH_MA_HI  = 5'd18,
        PH_MA_LO  = 5'd19
    } phase_t;

    // decoded tick as it travels from the front end to the sequencer
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] load_byte;
        logic       sda_in;
    } tick_entry_t;

    // zero reads as one tick, anything beyond the counter saturates
    function automatic logic [COUNT_BITS-1:0] eff_half(input logic [HALF_BITS-1:0] h);
        logic [31:0] hw;
        logic [31:0] lim;
        hw  = 32'(h);
        lim = 32'((64'd1 << COUNT_BITS) - 64'd1);
        if (hw == 32'd0)
        begin
            hw = 32'd1;
        end
        if (hw > lim)
        begin
            hw = lim;
        end
        return hw[COUNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/i2cbm_cmd_if.sv */
`default_nettype none

interface i2cbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       read_not_write;
    logic       sda_in;

    modport source (output valid, output command, output data_byte,
                    output read_not_write, output sda_in, input ready);
    modport sink   (input valid, input command, input data_byte,
                    input read_not_write, input sda_in, output ready);
endinterface

`default_nettype wire

/* rtl/i2cbm_res_if.sv */
`default_nettype none

interface i2cbm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] received_byte;
    logic       slave_nack;

    modport source (output valid, output scl_level, output sda_level, output sda_drive,
                    output busy_res, output done_res, output received_byte,
                    output slave_nack, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input sda_drive,
                    input busy_res, input done_res, input received_byte,
                    input slave_nack, output ready);
endinterface

`default_nettype wire

/* rtl/i2c_bit_level_master.sv */
// channel   dir  payload                                              handshake
// cmd_ch    in   command, data_byte, read_not_write, sda_in           valid/ready
// res_ch    out  scl_level, sda_level, sda_drive, busy_res, done_res,  valid/ready
//                received_byte, slave_nack
// cfg       in   cfg_wdata (half_period_ticks)                        cfg_we
//
// One transaction in gives one transaction out; the sequencer takes one tick per cycle
// while the result is not stalled. Each tick is decoded into a two-entry queue, then the
// phase update goes into the result register. Reset leaves the bus released high with SDA
// driven and the half period at 50 ticks. A stalled result holds the sequencer; the queue
// holds up to two ticks before the input side stalls.
`default_nettype none

module i2c_bit_level_master
    import i2cbm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [HALF_BITS-1:0] cfg_wdata,
    i2cbm_cmd_if.sink                 cmd_ch,
    i2cbm_res_if.source               res_ch
);

    tick_entry_t push_entry;
    tick_entry_t head;
    logic        push;
    logic        q_ready;
    logic        pop;
    logic        head_valid;

    i2cbm_front u_front (
        .cmd_ch  (cmd_ch),
        .q_ready (q_ready),
        .q_entry (push_entry),
        .q_push  (push)
    );

    i2cbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .ready      (q_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    i2cbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_head    (head),
        .q_valid   (head_valid),
        .q_pop     (pop),
        .res_ch    (res_ch)
    );

endmodule

`default_nettype wire

/* rtl/i2cbm_front.sv */
`default_nettype none

module i2cbm_front
    import i2cbm_pkg::*;
(
    i2cbm_cmd_if.sink   cmd_ch,
    input  wire logic   q_ready,
    output tick_entry_t q_entry,
    output logic        q_push
);

    cmd_t cmd;

    assign cmd          = cmd_t'(cmd_ch.command);
    assign cmd_ch.ready = q_ready;
    assign q_push       = cmd_ch.valid && q_ready;

    // pick the byte the sequencer loads into its shift register
    always_comb
    begin
        q_entry.cmd    = cmd;
        q_entry.sda_in = cmd_ch.sda_in;
        unique case (cmd)
            CMD_ADDR:  q_entry.load_byte = {cmd_ch.data_byte[6:0], cmd_ch.read_not_write};
            CMD_WRITE: q_entry.load_byte = cmd_ch.data_byte;
            default:   q_entry.load_byte = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/i2cbm_queue.sv */
`default_nettype none

module i2cbm_queue
    import i2cbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire tick_entry_t push_entry,
    output logic             ready,
    input  wire logic        pop,
    output tick_entry_t      head,
    output logic             head_valid
);

    tick_entry_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign ready      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/i2cbm_back.sv */
`default_nettype none

module i2cbm_back
    import i2cbm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [HALF_BITS-1:0] cfg_wdata,
    input  wire tick_entry_t      q_head,
    input  wire logic             q_valid,
    output logic                  q_pop,
    i2cbm_res_if.source           res_ch
);

    logic [HALF_BITS-1:0]  half_reg;
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] tick_reg, tick_next, tick_sum, eff;
    logic [3:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  drive_reg, drive_next;
    logic                  ack_reg, ack_next;
    logic                  pend_reg, pend_next;
    logic [7:0]            rx_reg, rx_next;
    logic                  done;
    logic                  go;
    logic                  fin;
    phase_t                target;

    logic                  out_valid_reg;
    logic                  out_done_reg;

    assign q_pop = q_valid && (!out_valid_reg || res_ch.ready);
    assign eff   = eff_half(half_reg);

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        ack_next   = ack_reg;
        pend_next  = pend_reg;
        rx_next    = rx_reg;
        tick_sum   = tick_reg + COUNT_BITS'(1);
        go         = 1'b0;
        fin        = 1'b0;
        target     = PH_IDLE;

        if (q_pop)
        begin
            if (phase_reg == PH_IDLE)
            begin
                bit_next = 4'd0;
                unique case (q_head.cmd)
                    CMD_START:
                    begin
                        go = 1'b1; target = PH_ST_A;
                    end
                    CMD_STOP:
                    begin
                        go = 1'b1; target = PH_SP_A;
                    end
                    CMD_WRITE:
                    begin
                        shift_next = q_head.load_byte;
                        go = 1'b1; target = PH_WR_SET;
                    end
                    CMD_READ:
                    begin
                        shift_next = 8'd0;
                        go = 1'b1; target = PH_RD_REL;
                    end
                    CMD_ACK:
                    begin
                        sda_next = 1'b0; drive_next = 1'b1; scl_next = 1'b0;
                        go = 1'b1; target = PH_MA_SET;
                    end
                    CMD_NACK:
                    begin
                        sda_next = 1'b1; drive_next = 1'b1; scl_next = 1'b0;
                        go = 1'b1; target = PH_MA_SET;
                    end
                    CMD_ADDR:
                    begin
                        shift_next = q_head.load_byte;
                        pend_next  = 1'b1;
                        go = 1'b1; target = PH_ST_A;
                    end
                    default: ;
                endcase
            end
            else
            begin
                tick_next = tick_sum;
                if (tick_sum >= eff)
                begin
                    unique case (phase_reg)
                        PH_ST_A:   begin go = 1'b1; target = PH_ST_B; end
                        PH_ST_B:   begin go = 1'b1; target = PH_ST_C; end
                        PH_ST_C:
                        begin
                            scl_next = 1'b0;
                            if (pend_reg)
                            begin
                                pend_next = 1'b0;
                                bit_next  = 4'd0;
                                go = 1'b1; target = PH_WR_SET;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        PH_SP_A:   begin go = 1'b1; target = PH_SP_B; end
                        PH_SP_B:   begin sda_next = 1'b1; fin = 1'b1; end
                        PH_WR_SET: begin go = 1'b1; target = PH_WR_HI; end
                        PH_WR_HI:  begin go = 1'b1; target = PH_WR_LO; end
                        PH_WR_LO:
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next   = bit_reg + 4'd1;
                            go = 1'b1;
                            target = (bit_next < BITS_PER_BYTE) ? PH_WR_SET : PH_AK_REL;
                        end
                        PH_AK_REL: begin go = 1'b1; target = PH_AK_HI; end
                        PH_AK_HI:
                        begin
                            ack_next = q_head.sda_in;
                            go = 1'b1; target = PH_AK_LO;
                        end
                        PH_AK_LO:  begin go = 1'b1; target = PH_AK_END; end
                        PH_AK_END: fin = 1'b1;
                        PH_RD_REL: begin go = 1'b1; target = PH_RD_HI; end
                        PH_RD_HI:
                        begin
                            shift_next = {shift_reg[6:0], q_head.sda_in};
                            go = 1'b1; target = PH_RD_LO;
                        end
                        PH_RD_LO:
                        begin
                            bit_next = bit_reg + 4'd1;
                            go = 1'b1;
                            target = (bit_next < BITS_PER_BYTE) ? PH_RD_HI : PH_RD_END;
                        end
                        PH_RD_END:
                        begin
                            drive_next = 1'b1;
                            rx_next    = shift_reg;
                            fin = 1'b1;
                        end
                        PH_MA_SET: begin go = 1'b1; target = PH_MA_HI; end
                        PH_MA_HI:  begin go = 1'b1; target = PH_MA_LO; end
                        PH_MA_LO:  begin sda_next = 1'b0; fin = 1'b1; end
                        default:   fin = 1'b1;
                    endcase
                end
            end
        end

        // entry actions of the new phase see the updated shift register
        if (go)
        begin
            phase_next = target;
            tick_next  = '0;
            unique case (target)
                PH_ST_A:   begin sda_next = 1'b1; drive_next = 1'b1; end
                PH_ST_B:   scl_next = 1'b1;
                PH_ST_C:   sda_next = 1'b0;
                PH_SP_A:   begin sda_next = 1'b0; drive_next = 1'b1; end
                PH_SP_B:   scl_next = 1'b1;
                PH_WR_SET:
                begin
                    scl_next = 1'b0; drive_next = 1'b1; sda_next = shift_next[7];
                end
                PH_WR_HI:  scl_next = 1'b1;
                PH_WR_LO:  scl_next = 1'b0;
                PH_AK_REL: drive_next = 1'b0;
                PH_AK_HI:  scl_next = 1'b1;
                PH_AK_LO:  scl_next = 1'b0;
                PH_AK_END: drive_next = 1'b1;
                PH_RD_REL: begin drive_next = 1'b0; scl_next = 1'b0; end
                PH_RD_HI:  scl_next = 1'b1;
                PH_RD_LO:  scl_next = 1'b0;
                PH_MA_HI:  scl_next = 1'b1;
                PH_MA_LO:  scl_next = 1'b0;
                default: ;
            endcase
        end

        done = fin;
        if (fin)
        begin
            phase_next = PH_IDLE;
            tick_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= HALF_RESET;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= 4'd0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b1;
            ack_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            rx_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_reg <= cfg_wdata;
            end
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drive_reg <= drive_next;
            ack_reg   <= ack_next;
            pend_reg  <= pend_next;
            rx_reg    <= rx_next;
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                out_done_reg  <= done;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // state registers only move on a pop, so they double as the result payload
    assign res_ch.valid         = out_valid_reg;
    assign res_ch.scl_level     = scl_reg;
    assign res_ch.sda_level     = sda_reg;
    assign res_ch.sda_drive     = drive_reg;
    assign res_ch.busy_res      = (phase_reg != PH_IDLE);
    assign res_ch.done_res      = out_done_reg;
    assign res_ch.received_byte = rx_reg;
    assign res_ch.slave_nack    = ack_reg;

endmodule

`default_nettype wire
